/* hw/rtl/playfair_encryptor_macros.svh */
// assertion macros for the playfair encryptor, used by the back part
`ifndef PLAYFAIR_ENCRYPTOR_MACROS_SVH
`define PLAYFAIR_ENCRYPTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define PF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pf assertion failed");

// next-cycle implication, checked out of reset
`define PF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pf assertion failed");

`endif

/* hw/rtl/pf_pkg.sv */
// types and constants shared by the playfair encryptor
package pf_pkg;

    localparam logic [1:0] FUNC_KEY  = 2'd0;
    localparam logic [1:0] FUNC_DONE = 2'd1;
    localparam logic [1:0] FUNC_MSG  = 2'd2;
    localparam logic [1:0] FUNC_END  = 2'd3;

    localparam logic [4:0] CODE_I    = 5'd8;
    localparam logic [4:0] CODE_J    = 5'd9;
    localparam logic [4:0] CODE_Q    = 5'd16;
    localparam logic [4:0] CODE_X    = 5'd23;
    localparam logic [4:0] CODE_LAST = 5'd25;

    localparam int LETTERS   = 26;
    localparam int SQ_DEPTH  = 25;
    localparam logic [4:0] SQ_CELLS = 5'd25;
    localparam logic [2:0] SQ_MAX   = 3'd4;
    localparam int POS_W     = 6;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [1:0] func;
        logic [4:0] letter;
    } in_item_t;

    typedef struct packed {
        logic [4:0] cipher_letter;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] code;
    } q_item_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

/* hw/rtl/pf_ram.sv */
// generic single write, single read ram with registered read data
module pf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/pf_front.sv */
// input stage: drops bad codes, folds j to i, hands beats to the queue
module pf_front import pf_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_item_t item,
    output hs_t      push,
    input  logic     push_ready,
    output q_item_t  push_item
);

    logic    stage_valid_reg;
    logic    stage_valid_next;
    q_item_t stage_item_reg;
    logic    accept;
    logic    code_ok;

    assign item_ready = !stage_valid_reg || push_ready;
    assign accept     = item_valid && item_ready;
    assign code_ok    = (item.letter <= CODE_LAST);

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (stage_valid_reg && push_ready)
        begin
            stage_valid_next = 1'b0;
        end
        if (accept && code_ok)
        begin
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && code_ok)
        begin
            stage_item_reg.op   <= item.func;
            stage_item_reg.code <= (item.letter == CODE_J) ? CODE_I : item.letter;
        end
    end

    assign push.valid = stage_valid_reg;
    assign push.ready = push_ready;
    assign push_item  = stage_item_reg;

endmodule

/* hw/rtl/pf_fifo.sv */
// short queue between the front and back parts
module pf_fifo import pf_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  q_item_t push_item,
    output logic    pop_valid,
    input  logic    pop_ready,
    output q_item_t pop_item
);

    q_item_t         entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != (Q_AW+1)'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hw/rtl/pf_back.sv */
// back part: key square build, letter pairing and pair encipher
`include "playfair_encryptor_macros.svh"

module pf_back import pf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  q_item_t   pop_item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_FILL  = 4'd1;
    localparam logic [3:0] B_RDA   = 4'd2;
    localparam logic [3:0] B_RDB   = 4'd3;
    localparam logic [3:0] B_IDX   = 4'd4;
    localparam logic [3:0] B_SQ2   = 4'd5;
    localparam logic [3:0] B_CAP   = 4'd6;
    localparam logic [3:0] B_EMIT1 = 4'd7;
    localparam logic [3:0] B_EMIT2 = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [LETTERS-1:0] used_reg;
    logic [4:0]         fill_count_reg;
    logic [2:0]         fill_row_reg, fill_col_reg;
    logic               key_ready_reg, key_ready_next;
    logic [4:0]         held_reg, held_next;
    logic               held_valid_reg, held_valid_next;
    logic [4:0]         k_reg, k_next;
    logic [4:0]         a_reg, a_next;
    logic [4:0]         b_reg, b_next;
    logic [POS_W-1:0]   pa_reg;
    logic [4:0]         idx2_reg;
    logic [4:0]         o1_reg, o2_reg;

    logic             place_req;
    logic [4:0]       place_code;
    logic             place_en;
    logic             pos_re;
    logic [4:0]       pos_raddr;
    logic [POS_W-1:0] pos_rdata;
    logic             sq_re;
    logic [4:0]       sq_raddr;
    logic [4:0]       sq_rdata;
    logic [4:0]       filler;
    logic             take;

    logic [2:0] ra, ca, rb, cb;
    logic [2:0] r1, c1, r2, c2;
    logic [4:0] idx1, idx2;

    function automatic logic [2:0] inc5(input logic [2:0] v);
        return (v == SQ_MAX) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [4:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    assign filler   = (held_reg == CODE_X) ? CODE_Q : CODE_X;
    assign take     = (state_reg == B_IDLE) && pop_valid;
    assign pop_ready = (state_reg == B_IDLE);
    assign place_en = place_req && !used_reg[place_code] && (fill_count_reg < SQ_CELLS);

    assign ra = pa_reg[5:3];
    assign ca = pa_reg[2:0];
    assign rb = pos_rdata[5:3];
    assign cb = pos_rdata[2:0];

    always_comb
    begin
        if (ra == rb)
        begin
            r1 = ra;       c1 = inc5(ca);
            r2 = rb;       c2 = inc5(cb);
        end
        else if (ca == cb)
        begin
            r1 = inc5(ra); c1 = ca;
            r2 = inc5(rb); c2 = cb;
        end
        else
        begin
            r1 = ra;       c1 = cb;
            r2 = rb;       c2 = ca;
        end
        idx1 = cell_idx(r1, c1);
        idx2 = cell_idx(r2, c2);
    end

    always_comb
    begin
        state_next      = state_reg;
        key_ready_next  = key_ready_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        k_next          = k_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        place_req       = 1'b0;
        place_code      = pop_item.code;
        pos_re          = 1'b0;
        pos_raddr       = a_reg;
        sq_re           = 1'b0;
        sq_raddr        = idx1;
        case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    case (pop_item.op)
                        FUNC_KEY:
                        begin
                            place_req = !key_ready_reg;
                        end
                        FUNC_DONE:
                        begin
                            if (!key_ready_reg)
                            begin
                                k_next     = '0;
                                state_next = B_FILL;
                            end
                        end
                        FUNC_MSG:
                        begin
                            if (key_ready_reg)
                            begin
                                if (!held_valid_reg)
                                begin
                                    held_next       = pop_item.code;
                                    held_valid_next = 1'b1;
                                end
                                else
                                begin
                                    a_next     = held_reg;
                                    state_next = B_RDA;
                                    if (pop_item.code == held_reg)
                                    begin
                                        b_next = filler;
                                    end
                                    else
                                    begin
                                        b_next          = pop_item.code;
                                        held_valid_next = 1'b0;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            if (key_ready_reg && held_valid_reg)
                            begin
                                held_valid_next = 1'b0;
                                a_next          = held_reg;
                                b_next          = filler;
                                state_next      = B_RDA;
                            end
                        end
                    endcase
                end
            end
            B_FILL:
            begin
                place_code = k_reg;
                place_req  = (k_reg != CODE_J);
                if (k_reg == CODE_LAST)
                begin
                    key_ready_next = 1'b1;
                    state_next     = B_IDLE;
                end
                else
                begin
                    k_next = k_reg + 5'd1;
                end
            end
            B_RDA:
            begin
                pos_re     = 1'b1;
                pos_raddr  = a_reg;
                state_next = B_RDB;
            end
            B_RDB:
            begin
                pos_re     = 1'b1;
                pos_raddr  = b_reg;
                state_next = B_IDX;
            end
            B_IDX:
            begin
                sq_re      = 1'b1;
                sq_raddr   = idx1;
                state_next = B_SQ2;
            end
            B_SQ2:
            begin
                sq_re      = 1'b1;
                sq_raddr   = idx2_reg;
                state_next = B_CAP;
            end
            B_CAP:
            begin
                state_next = B_EMIT1;
            end
            B_EMIT1:
            begin
                if (result_ready)
                begin
                    state_next = B_EMIT2;
                end
            end
            B_EMIT2:
            begin
                if (result_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            used_reg       <= '0;
            fill_count_reg <= '0;
            fill_row_reg   <= '0;
            fill_col_reg   <= '0;
            key_ready_reg  <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            key_ready_reg  <= key_ready_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            if (place_en)
            begin
                used_reg[place_code] <= 1'b1;
                fill_count_reg       <= fill_count_reg + 5'd1;
                if (fill_col_reg == SQ_MAX)
                begin
                    fill_col_reg <= '0;
                    fill_row_reg <= fill_row_reg + 3'd1;
                end
                else
                begin
                    fill_col_reg <= fill_col_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        a_reg <= a_next;
        b_reg <= b_next;
        if (state_reg == B_RDB)
        begin
            pa_reg <= pos_rdata;
        end
        if (state_reg == B_IDX)
        begin
            idx2_reg <= idx2;
        end
        if (state_reg == B_SQ2)
        begin
            o1_reg <= sq_rdata;
        end
        if (state_reg == B_CAP)
        begin
            o2_reg <= sq_rdata;
        end
    end

    pf_ram #(
        .WIDTH (POS_W),
        .DEPTH (LETTERS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (place_en),
        .waddr (place_code),
        .wdata ({fill_row_reg, fill_col_reg}),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    pf_ram #(
        .WIDTH (5),
        .DEPTH (SQ_DEPTH)
    ) u_sq_ram (
        .clk   (clk),
        .we    (place_en),
        .waddr (fill_count_reg),
        .wdata (place_code),
        .re    (sq_re),
        .raddr (sq_raddr),
        .rdata (sq_rdata)
    );

    assign result_valid         = (state_reg == B_EMIT1) || (state_reg == B_EMIT2);
    assign result.cipher_letter = (state_reg == B_EMIT2) ? o2_reg : o1_reg;
    assign result.last          = (state_reg == B_EMIT2);

    `PF_ASSERT_NXT(a_first_then_second, (state_reg == B_EMIT1) && result_ready,
                   state_reg == B_EMIT2)
    `PF_ASSERT_IMP(a_pop_only_idle, pop_valid && pop_ready, state_reg == B_IDLE)
    `PF_ASSERT_IMP(a_armed_full, key_ready_reg, fill_count_reg == SQ_CELLS)
    `PF_ASSERT_IMP(a_no_overfill, place_en, !key_ready_reg && fill_count_reg < SQ_CELLS)

endmodule

/* hw/rtl/playfair_encryptor.sv */
// playfair encryptor top level: front stage, queue and back part
// a pair's first cipher beat follows back states rda, rdb, idx, sq2 and cap
// throughput: one key or held letter per cycle while the back part is idle; a pair is
//   enciphered in turn through the single read ports of the position and square rams
// key done sweeps the 26 letter codes, one per cycle, before the next beat is taken
// reset (rst_n low, asynchronous) empties the queue, marks all letters unused, disarms
module playfair_encryptor import pf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    hs_t     push;
    logic    push_ready;
    q_item_t push_item;
    logic    pop_valid;
    logic    pop_ready;
    q_item_t pop_item;

    pf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    pf_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push.valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    pf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
